>>> rtl/lpbt_pkg.sv
package lpbt_pkg;

    localparam int NUM_FRAMES_DEF   = 16;
    localparam int PIN_BITS_DEF     = 8;
    localparam int PAGE_ID_BITS_DEF = 32;

    typedef enum logic [2:0] {
        KIND_NEW    = 3'd0,
        KIND_FETCH  = 3'd1,
        KIND_UNPIN  = 3'd2,
        KIND_FLUSH  = 3'd3,
        KIND_FLUSHA = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_MISSING  = 2'd2,
        ST_NEGATIVE = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] page_id;
        logic               mark_dirty;
    } req_t;

    typedef struct packed {
        logic [3:0]         frame_index;
        logic [1:0]         status;
        logic               hit;
        logic               load_needed;
        logic               zero_fill;
        logic               writeback_valid;
        logic signed [31:0] writeback_page;
        logic signed [31:0] page_out;
        logic               last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, evaluate lookup/pick
        logic commit;    // apply single-result update and emit
        logic scan_emit; // flush-all: emit current dirty frame and clear it
        logic scan_none; // flush-all: emit empty result
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic flush_all;
        logic invalid;
        logic any_dirty;
        logic more_dirty;
    } sts_t;

endpackage

>>> rtl/lpbt_datapath.sv
module lpbt_datapath #(
    parameter int PIN_BITS     = lpbt_pkg::PIN_BITS_DEF,
    parameter int PAGE_ID_BITS = lpbt_pkg::PAGE_ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  lpbt_pkg::req_t req,
    input  lpbt_pkg::ctl_t ctl,
    output lpbt_pkg::sts_t sts,
    output lpbt_pkg::rsp_t rsp,
    output logic           rsp_strobe
);
    import lpbt_pkg::*;

    localparam int NUM_FRAMES = NUM_FRAMES_DEF;
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};

    logic [NUM_FRAMES-1:0]   used_reg, dirty_reg;
    logic [PIN_BITS-1:0]     pin_reg  [NUM_FRAMES];
    logic [FW-1:0]           rank_reg [NUM_FRAMES];
    logic [PAGE_ID_BITS-1:0] page_mem [NUM_FRAMES];

    // captured request and evaluation results
    logic [2:0]              kind_reg;
    logic [PAGE_ID_BITS-1:0] id_reg;
    logic                    neg_reg, mdirty_reg, found_reg, pick_ok_reg;
    logic [FW-1:0]           found_idx_reg, pick_idx_reg;
    logic [PAGE_ID_BITS-1:0] victim_page_reg;

    rsp_t rsp_reg, rsp_next;
    logic strobe_reg;

    // take the low bits of the request id (sign-extended later for output)
    logic [PAGE_ID_BITS-1:0] id_in;
    assign id_in = req.page_id[PAGE_ID_BITS-1:0];

    // lookup, empty search, LRU search (combinational, captured on load)
    logic              f_found, e_found, v_found;
    logic [FW-1:0]     f_idx, e_idx, v_idx;
    always_comb
    begin
        f_found = 1'b0; f_idx = '0;
        e_found = 1'b0; e_idx = '0;
        v_found = 1'b0; v_idx = '0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (!f_found && used_reg[i] && page_mem[i] == id_in)
            begin
                f_found = 1'b1; f_idx = FW'(i);
            end
            if (!e_found && !used_reg[i])
            begin
                e_found = 1'b1; e_idx = FW'(i);
            end
            if (pin_reg[i] == '0 && (!v_found || rank_reg[i] > rank_reg[v_idx]))
            begin
                v_found = 1'b1; v_idx = FW'(i);
            end
        end
    end

    // first dirty used frame for flush all
    logic [NUM_FRAMES-1:0] dmask;
    logic                  d_any, d_more;
    logic [FW-1:0]         d_idx;
    assign dmask = used_reg & dirty_reg;
    always_comb
    begin
        d_any = 1'b0; d_idx = '0; d_more = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (dmask[i])
            begin
                if (d_any)
                    d_more = 1'b1;
                else
                begin
                    d_any = 1'b1; d_idx = FW'(i);
                end
            end
        end
    end

    assign sts.flush_all  = (kind_reg == KIND_FLUSHA);
    assign sts.invalid    = (kind_reg > KIND_FLUSHA);
    assign sts.any_dirty  = d_any;
    assign sts.more_dirty = d_more;

    logic [FW-1:0] tgt;
    logic          do_place, touch_en;
    always_comb
    begin
        do_place = 1'b0;
        tgt      = found_idx_reg;
        touch_en = 1'b0;
        if (!neg_reg && (kind_reg == KIND_NEW || kind_reg == KIND_FETCH))
        begin
            if (found_reg)
                touch_en = 1'b1;
            else if (pick_ok_reg)
            begin
                do_place = 1'b1; touch_en = 1'b1; tgt = pick_idx_reg;
            end
        end
    end

    logic signed [31:0] id32;
    assign id32 = 32'(signed'(id_reg));

    // next result item
    always_comb
    begin
        rsp_next = rsp_reg;
        if (ctl.commit)
        begin
            rsp_next          = '0;
            rsp_next.last     = 1'b1;
            rsp_next.page_out = id32;
            if (neg_reg)
                rsp_next.status = ST_NEGATIVE;
            else if (kind_reg == KIND_UNPIN || kind_reg == KIND_FLUSH)
            begin
                if (!found_reg)
                    rsp_next.status = ST_MISSING;
                else
                begin
                    rsp_next.frame_index = 4'(found_idx_reg);
                    if (kind_reg == KIND_FLUSH && dirty_reg[found_idx_reg])
                    begin
                        rsp_next.writeback_valid = 1'b1;
                        rsp_next.writeback_page  = id32;
                    end
                end
            end
            else if (found_reg)
            begin
                rsp_next.frame_index = 4'(found_idx_reg);
                if (kind_reg == KIND_FETCH)
                    rsp_next.hit = 1'b1;
                else
                    rsp_next.zero_fill = 1'b1;
            end
            else if (!pick_ok_reg)
                rsp_next.status = ST_FULL;
            else
            begin
                rsp_next.frame_index = 4'(pick_idx_reg);
                rsp_next.load_needed = (kind_reg == KIND_FETCH);
                rsp_next.zero_fill   = (kind_reg == KIND_NEW);
                if (used_reg[pick_idx_reg] && dirty_reg[pick_idx_reg])
                begin
                    rsp_next.writeback_valid = 1'b1;
                    rsp_next.writeback_page  = 32'(signed'(victim_page_reg));
                end
            end
        end
        else if (ctl.scan_emit)
        begin
            rsp_next                 = '0;
            rsp_next.frame_index     = 4'(d_idx);
            rsp_next.writeback_valid = 1'b1;
            rsp_next.writeback_page  = 32'(signed'(page_mem[d_idx]));
            rsp_next.page_out        = 32'(signed'(page_mem[d_idx]));
            rsp_next.last            = !d_more;
        end
        else if (ctl.scan_none)
        begin
            rsp_next      = '0;
            rsp_next.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            dirty_reg  <= '0;
            strobe_reg <= 1'b0;
            kind_reg   <= '0;
            rsp_reg    <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                pin_reg[i]  <= '0;
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            strobe_reg <= ctl.commit | ctl.scan_emit | ctl.scan_none;
            rsp_reg    <= rsp_next;
            if (ctl.load)
            begin
                kind_reg        <= req.kind;
                id_reg          <= id_in;
                neg_reg         <= id_in[PAGE_ID_BITS-1];
                mdirty_reg      <= req.mark_dirty;
                found_reg       <= f_found;
                found_idx_reg   <= f_idx;
                pick_ok_reg     <= e_found | v_found;
                pick_idx_reg    <= e_found ? e_idx : v_idx;
                victim_page_reg <= page_mem[e_found ? e_idx : v_idx];
            end
            if (ctl.commit)
            begin
                if (neg_reg)
                begin
                end
                else if (kind_reg == KIND_UNPIN || kind_reg == KIND_FLUSH)
                begin
                    if (found_reg)
                    begin
                        if (kind_reg == KIND_UNPIN)
                        begin
                            if (pin_reg[found_idx_reg] != '0)
                                pin_reg[found_idx_reg] <= pin_reg[found_idx_reg]
                                                          - PIN_BITS'(1);
                            if (mdirty_reg)
                                dirty_reg[found_idx_reg] <= 1'b1;
                        end
                        else if (dirty_reg[found_idx_reg])
                            dirty_reg[found_idx_reg] <= 1'b0;
                    end
                end
                else if (found_reg)
                begin
                    if (kind_reg == KIND_FETCH)
                    begin
                        if (pin_reg[found_idx_reg] != PIN_MAX)
                            pin_reg[found_idx_reg] <= pin_reg[found_idx_reg]
                                                      + PIN_BITS'(1);
                    end
                    else
                    begin
                        pin_reg[found_idx_reg]   <= PIN_BITS'(1);
                        dirty_reg[found_idx_reg] <= 1'b1;
                    end
                end
                else if (pick_ok_reg)
                begin
                    used_reg[pick_idx_reg]  <= 1'b1;
                    pin_reg[pick_idx_reg]   <= PIN_BITS'(1);
                    dirty_reg[pick_idx_reg] <= (kind_reg == KIND_NEW);
                end
                // recency: ranks below tgt's +1; all +1 on empty fill
                if (touch_en)
                begin
                    for (int i = 0; i < NUM_FRAMES; i++)
                    begin
                        if (used_reg[i] && FW'(i) != tgt)
                        begin
                            if (do_place && !used_reg[tgt])
                                rank_reg[i] <= rank_reg[i] + FW'(1);
                            else if (rank_reg[i] < rank_reg[tgt])
                                rank_reg[i] <= rank_reg[i] + FW'(1);
                        end
                    end
                    rank_reg[tgt] <= '0;
                end
            end
            if (ctl.scan_emit)
                dirty_reg[d_idx] <= 1'b0;
        end
    end

    // page id store: undefined until written
    always_ff @(posedge clk)
    begin
        if (ctl.commit && do_place)
            page_mem[pick_idx_reg] <= id_reg;
    end

    assign rsp        = rsp_reg;
    assign rsp_strobe = strobe_reg;

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load, ctl.commit, ctl.scan_emit, ctl.scan_none}))
        else $error("multiple datapath commands");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_emit |=> !dirty_reg[$past(d_idx)])
        else $error("flushed frame still dirty");
    a_wb_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.scan_emit |-> d_any)
        else $error("scan emit with no dirty frame");
endmodule

>>> rtl/lpbt_ctrl.sv
module lpbt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  lpbt_pkg::sts_t sts,
    output lpbt_pkg::ctl_t ctl,
    output logic           busy
);
    import lpbt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_SCAN = 4'b0100,
        S_WAIT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (sts.invalid)
                    state_next = S_IDLE;
                else if (sts.flush_all)
                begin
                    if (sts.any_dirty)
                    begin
                        ctl.scan_emit = 1'b1;
                        state_next = sts.more_dirty ? S_WAIT : S_IDLE;
                    end
                    else
                    begin
                        ctl.scan_none = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // the wait state lets the cleared dirty bit settle
            S_WAIT: state_next = S_SCAN;
            S_SCAN:
            begin
                ctl.scan_emit = 1'b1;
                state_next = sts.more_dirty ? S_WAIT : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> state_reg == S_EVAL)
        else $error("load did not enter eval");
    a_scan_dirty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> sts.any_dirty)
        else $error("scan without dirty frame");
    a_scan_follow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> $past(state_reg) == S_WAIT)
        else $error("scan not preceded by wait");
endmodule

>>> rtl/lru_page_buffer_pool_tracker.sv
// channel   ports                        handshake
// request   start, busy, req             taken when start && !busy
// result    rsp_strobe, rsp              one-cycle strobe per item, cannot stall
//
// Single-result requests: busy while evaluating; result registered from evaluation;
// a new request can be taken while the previous result is shown, not while busy.
// Flush all: evaluation emits the first dirty frame, then wait and scan states alternate,
// one frame per scan; with no dirty frame, one empty result. Unknown kinds: busy, no result.
// Reset clears used, dirty, pin and rank state at once, not page ids; no clearing pass.
// The receiver cannot stall: each result is shown for exactly one cycle.
module lru_page_buffer_pool_tracker #(
    parameter int PIN_BITS     = lpbt_pkg::PIN_BITS_DEF,
    parameter int PAGE_ID_BITS = lpbt_pkg::PAGE_ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  lpbt_pkg::req_t req,
    output logic           rsp_strobe,
    output lpbt_pkg::rsp_t rsp
);
    import lpbt_pkg::*;

    ctl_t ctl;
    sts_t sts;

    lpbt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    lpbt_datapath #(
        .PIN_BITS     (PIN_BITS),
        .PAGE_ID_BITS (PAGE_ID_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .ctl        (ctl),
        .sts        (sts),
        .rsp        (rsp),
        .rsp_strobe (rsp_strobe)
    );
endmodule
